// ===== design/lbrs_pkg.sv =====
// Package for the LED blink request sequencer.
// Holds the item structs for both channels, the stored request layout and the
// steady-level code. No dependencies.
`timescale 1ns / 1ps

package lbrs_pkg;

  // A blink count of all ones marks a steady-level command.
  localparam logic [15:0] SteadyCode = 16'hFFFF;

  // Item kinds on the input channel.
  localparam logic KindEnqueue = 1'b0;
  localparam logic KindTick    = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] blink_count;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
  } in_item_t;

  typedef struct packed {
    logic       led_lit;
    logic       request_accepted;
    logic [3:0] queue_level;
    logic       sequencer_busy;
  } out_item_t;

  // One queued blink request as it sits in the request RAM.
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] on_t;
    logic [15:0] off_t;
  } req_t;

endpackage

// ===== design/lbrs_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the request queue storage. No dependencies.
`timescale 1ns / 1ps

module lbrs_ram #(
  parameter int Width = 48,
  parameter int Depth = 8
) (
  input  logic                                    clk_i,
  input  logic                                    wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                        wr_data_i,
  input  logic                                    rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                        rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/led_blink_request_sequencer.sv =====
// Top level of the LED blink request sequencer: request queue, blink engine
// and output register. Depends on lbrs_pkg and lbrs_ram.
`timescale 1ns / 1ps

// Usage. The input channel carries items of two kinds. An enqueue item holds
// a blink request (count, on ticks, off ticks) that goes into a ring queue of
// QUEUE_DEPTH entries; it is dropped when the queue is full. A tick item
// advances the sequencer by one step: an idle sequencer pops the oldest
// request, a busy one plays it (steady level for count 0xFFFF, otherwise
// on/off phases for count repeats). Every item gives exactly one result item
// with the LED level, whether the request was stored, the queue level and the
// busy flag after that item.
// A result appears in the cycle after its item is accepted, and one item is
// taken every cycle while the input is not stalled. The queue lives in a
// RAM with one registered read port; the read of a popped entry is issued on
// the pop tick and its read register then serves as the active request until
// the next pop, so the blink engine sees it on the following busy tick.
// Reset clears the pointers, fill count, counters, LED level and the output
// valid; the queue RAM needs no clearing. When the receiver stalls, the
// result stays in the output register and the input is stalled in the same
// cycle; while the output register is empty or being drained, input flows.

module led_blink_request_sequencer #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lbrs_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lbrs_pkg::out_item_t out_item_o
);

  import lbrs_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  // Queue control.
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW+3:0] cnt_ext;

  // Blink engine state.
  logic        playing_q, playing_d;
  logic        lamp_q, lamp_d;
  logic [15:0] rep_q, rep_d;
  logic [15:0] on_el_q, on_el_d;
  logic [15:0] off_el_q, off_el_d;
  logic [15:0] on_nx, off_nx;
  logic        lamp_nx;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  logic accept, is_tick, enq_ok, pop, busy_tick;
  req_t act;
  logic [$bits(req_t)-1:0] ram_rdata;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_tick    = (in_item_i.kind == KindTick);
  assign enq_ok     = accept & (in_item_i.kind == KindEnqueue) & (cnt_q < FullCnt);
  assign pop        = accept & is_tick & ~playing_q & (cnt_q != '0);
  assign busy_tick  = accept & is_tick & playing_q;

  // The read register of the RAM holds the request popped last; it is only
  // reloaded on the next pop, so later writes to that entry cannot disturb it.
  lbrs_ram #(
    .Width($bits(req_t)),
    .Depth(QUEUE_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (enq_ok),
    .wr_addr_i(wr_ptr_q),
    .wr_data_i({in_item_i.blink_count, in_item_i.on_ticks, in_item_i.off_ticks}),
    .rd_en_i  (pop),
    .rd_addr_i(rd_ptr_q),
    .rd_data_o(ram_rdata)
  );

  assign act = req_t'(ram_rdata);

  // Queue pointers and fill count. Enqueue and pop never share a cycle.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq_ok) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      cnt_d    = cnt_q + 1'b1;
    end else if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
    end
  end

  // One blink step: on phase first, then off phase, then close the repeat.
  always_comb begin
    lamp_nx = lamp_q;
    on_nx   = on_el_q;
    off_nx  = off_el_q;
    if (on_el_q < act.on_t) begin
      lamp_nx = 1'b1;
      on_nx   = on_el_q + 16'd1;
    end
    if ((on_nx >= act.on_t) && (off_el_q < act.off_t)) begin
      lamp_nx = 1'b0;
      off_nx  = off_el_q + 16'd1;
    end
  end

  always_comb begin
    playing_d = playing_q;
    lamp_d    = lamp_q;
    rep_d     = rep_q;
    on_el_d   = on_el_q;
    off_el_d  = off_el_q;
    if (pop) begin
      playing_d = 1'b1;
      rep_d     = '0;
      on_el_d   = '0;
      off_el_d  = '0;
    end else if (busy_tick) begin
      if (act.count == SteadyCode) begin
        // Steady command: (1,0) lights the LED, (0,1) darkens it.
        if ((act.on_t == 16'd1) && (act.off_t == 16'd0)) begin
          lamp_d = 1'b1;
        end
        if ((act.off_t == 16'd1) && (act.on_t == 16'd0)) begin
          lamp_d = 1'b0;
        end
        playing_d = 1'b0;
      end else if (rep_q < act.count) begin
        lamp_d = lamp_nx;
        if ((off_nx >= act.off_t) && (on_nx >= act.on_t)) begin
          rep_d    = rep_q + 16'd1;
          on_el_d  = '0;
          off_el_d = '0;
        end else begin
          on_el_d  = on_nx;
          off_el_d = off_nx;
        end
      end else begin
        playing_d = 1'b0;
        rep_d     = '0;
      end
    end
  end

  assign cnt_ext = {4'b0000, cnt_d};

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      cnt_q       <= '0;
      playing_q   <= 1'b0;
      lamp_q      <= 1'b0;
      rep_q       <= '0;
      on_el_q     <= '0;
      off_el_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      cnt_q       <= cnt_d;
      playing_q   <= playing_d;
      lamp_q      <= lamp_d;
      rep_q       <= rep_d;
      on_el_q     <= on_el_d;
      off_el_q    <= off_el_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q.led_lit          <= lamp_d;
      out_item_q.request_accepted <= enq_ok;
      out_item_q.queue_level      <= cnt_ext[3:0];
      out_item_q.sequencer_busy   <= playing_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The fill count never exceeds the queue depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue fill count above depth");

  // An empty queue has its pointers together.
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("empty queue with pointers apart");

  // A pop only happens while idle, and the sequencer is busy right after it.
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> playing_q)
    else $error("pop did not start playback");

  // A write and a pop never fall in the same cycle.
  a_no_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(enq_ok && pop))
    else $error("enqueue and pop in one cycle");

  // A result that is stalled keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_item_q)))
    else $error("stalled result changed");

endmodule
